[hdl/imuoc_pkg.sv]
// Shared types, codes and helpers for the IMU offset calibration block.
// Used by the channel interfaces and by every module; depends on nothing.
package imuoc_pkg;

	localparam int AXES        = 3;
	localparam int AXIS_W      = $clog2(AXES);
	localparam int SAMP_W      = 16;
	localparam int CORR_W      = SAMP_W + 1;
	localparam int SUM_W       = 32;
	localparam int COUNT_W     = 16;
	localparam int GRAV_W      = 15;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int DIV_STEPS   = SUM_W;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	// Command codes on the request channel
	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_START  = 2'd1;
	localparam logic [1:0] CMD_LOAD   = 2'd2;

	// Request classes handed from the front to the back
	typedef logic [1:0] cls_t;
	localparam cls_t CLS_SAMPLE = 2'd0;
	localparam cls_t CLS_START  = 2'd1;
	localparam cls_t CLS_LOAD   = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_VALUE = 1'd1;

	localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

	typedef logic signed [SAMP_W-1:0] samp_t;
	typedef logic signed [CORR_W-1:0] corr_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	typedef struct packed {
		cls_t  cls;
		samp_t x;
		samp_t y;
		samp_t z;
	} item_t;

	typedef struct packed {
		logic               go;
		logic [SUM_W-1:0]   dividend;
		logic [COUNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [CORR_W-1:0] quotient;
	} div_rsp_t;

	// Clamp a 19-bit signed value to the 16-bit offset range
	function automatic samp_t sat16(input logic signed [SAMP_W+2:0] v);
		if (v > 19'sd32767) begin
			return 16'sh7FFF;
		end else if (v < -19'sd32768) begin
			return 16'sh8000;
		end
		return v[SAMP_W-1:0];
	endfunction

endpackage

[hdl/imuoc_if.sv]
// Valid/ready channel interfaces: sample requests, results, config writes.
// Depends on imuoc_pkg.
interface imuoc_samp_if import imuoc_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] command;
	samp_t      sample_x;
	samp_t      sample_y;
	samp_t      sample_z;

	modport source(output valid, command, sample_x, sample_y, sample_z, input ready);
	modport sink(input valid, command, sample_x, sample_y, sample_z, output ready);
endinterface

interface imuoc_res_if import imuoc_pkg::*; ();
	logic  valid;
	logic  ready;
	corr_t corrected_x;
	corr_t corrected_y;
	corr_t corrected_z;
	logic  calibrating;
	logic  offsets_updated;

	modport source(output valid, corrected_x, corrected_y, corrected_z, calibrating,
		offsets_updated, input ready);
	modport sink(input valid, corrected_x, corrected_y, corrected_z, calibrating,
		offsets_updated, output ready);
endinterface

interface imuoc_cfg_if import imuoc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[hdl/imuoc_front.sv]
// Front end: accepts sample requests, classifies the command and queues them.
// Depends on imuoc_pkg and imuoc_samp_if.
module imuoc_front import imuoc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	imuoc_samp_if.sink   samp,
	output item_t        q_item,
	output logic         q_valid,
	input  logic         q_pop
);

	item_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               push;
	logic               pop;
	item_t              item_in;

	assign samp.ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push       = samp.valid && samp.ready;
	assign q_valid    = (count_q != '0);
	assign pop        = q_pop && q_valid;
	assign q_item     = mem_q[rd_ptr_q];

	// Classify the command; the unused code runs as a sample
	always_comb begin
		item_in.x = samp.sample_x;
		item_in.y = samp.sample_y;
		item_in.z = samp.sample_z;
		case (samp.command)
			CMD_LOAD:  item_in.cls = CLS_LOAD;
			CMD_START: item_in.cls = CLS_START;
			default:   item_in.cls = CLS_SAMPLE;
		endcase
	end

	// Write the queue entry
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/imuoc_div.sv]
// Shared restoring divider: unsigned 32-bit dividend by 16-bit divisor,
// one quotient bit per cycle. Depends on imuoc_pkg.
module imuoc_div import imuoc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0]     dvd_q;
	logic [COUNT_W-1:0]   rem_q;
	logic [COUNT_W-1:0]   dsr_q;
	logic [COUNT_W:0]     trial;
	logic                 fits;

	// Shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, dvd_q[SUM_W-1]};
	assign fits  = (trial >= {1'b0, dsr_q});

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q[CORR_W-1:0];

	// Hold the datapath
	always_ff @(posedge clk) begin
		if (req.go) begin
			dvd_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? COUNT_W'(trial - {1'b0, dsr_q}) : trial[COUNT_W-1:0];
			dvd_q <= {dvd_q[SUM_W-2:0], fits};
		end
	end

	// Count the steps and flag completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.go && (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

[hdl/imuoc_back.sv]
// Back end: offsets, calibration sums, config registers and result register;
// drives the shared divider at the end of a run. Depends on imuoc_pkg, interfaces.
module imuoc_back import imuoc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       q_item,
	input  logic        q_valid,
	output logic        q_pop,
	imuoc_cfg_if.sink   cfg,
	imuoc_res_if.source res,
	output div_req_t    div_req,
	input  div_rsp_t    div_rsp
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;

	logic               st_q;
	logic [AXIS_W-1:0]  axis_q;
	logic               go_q;
	samp_t              off_q [AXES];
	sum_t               sum_q [AXES];
	logic [COUNT_W-1:0] taken_q;
	logic               run_q;
	logic [COUNT_W-1:0] count_cfg_q;
	logic [GRAV_W-1:0]  grav_q;

	logic               res_valid_q;
	corr_t              res_x_q;
	corr_t              res_y_q;
	corr_t              res_z_q;
	logic               res_cal_q;
	logic               res_upd_q;

	samp_t              s [AXES];
	corr_t              corr [AXES];
	logic [COUNT_W-1:0] target;
	logic [COUNT_W:0]   taken_nx;
	logic               run_end;
	logic               issue;
	logic               div_kick;
	sum_t               sum_sel;
	logic signed [CORR_W:0]   q_signed;
	logic signed [CORR_W+1:0] q_wide;
	logic signed [CORR_W+1:0] z_val;
	samp_t              off_new;

	// Unpack the request and correct each axis
	always_comb begin
		s[0] = q_item.x;
		s[1] = q_item.y;
		s[2] = q_item.z;
		for (int i = 0; i < AXES; i++) begin
			corr[i] = corr_t'(s[i]) - corr_t'(off_q[i]);
		end
	end

	// Run bookkeeping
	assign target   = (count_cfg_q == '0) ? COUNT_W'(1) : count_cfg_q;
	assign taken_nx = {1'b0, taken_q} + 1'b1;
	assign run_end  = run_q && (taken_nx >= {1'b0, target});

	// Take a request only when idle and the result register frees up
	assign issue = (st_q == ST_IDLE) && q_valid && (!res_valid_q || res.ready);
	assign q_pop = issue;

	// Start the divider on the closing sample and after each axis but the last
	assign div_kick = (issue && run_end && (q_item.cls != CLS_LOAD)
		&& (q_item.cls != CLS_START))
		|| ((st_q == ST_DIV) && div_rsp.done && (axis_q != AXIS_Z));

	// Divider feed and signed, gravity-adjusted offset
	assign sum_sel          = sum_q[axis_q];
	assign div_req.go       = go_q;
	assign div_req.dividend = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
	assign div_req.divisor  = target;

	always_comb begin
		q_signed = sum_sel[SUM_W-1] ? -$signed({1'b0, div_rsp.quotient})
			: $signed({1'b0, div_rsp.quotient});
		q_wide = {q_signed[CORR_W], q_signed};
		z_val  = q_wide - $signed({{(CORR_W + 2 - GRAV_W){1'b0}}, grav_q});
		off_new = (axis_q == AXIS_Z) ? sat16(z_val) : sat16(q_wide);
	end

	assign cfg.ready           = 1'b1;
	assign res.valid           = res_valid_q;
	assign res.corrected_x     = res_x_q;
	assign res.corrected_y     = res_y_q;
	assign res.corrected_z     = res_z_q;
	assign res.calibrating     = res_cal_q;
	assign res.offsets_updated = res_upd_q;

	// Load the result register
	always_ff @(posedge clk) begin
		if (issue) begin
			case (q_item.cls)
				CLS_LOAD: begin
					res_x_q   <= '0;
					res_y_q   <= '0;
					res_z_q   <= '0;
					res_cal_q <= 1'b0;
					res_upd_q <= 1'b0;
				end
				CLS_START: begin
					res_x_q   <= corr_t'(s[0]);
					res_y_q   <= corr_t'(s[1]);
					res_z_q   <= corr_t'(s[2]);
					res_cal_q <= 1'b1;
					res_upd_q <= 1'b0;
				end
				default: begin
					res_x_q   <= corr[0];
					res_y_q   <= corr[1];
					res_z_q   <= corr[2];
					res_cal_q <= run_q && !run_end;
					res_upd_q <= run_end;
				end
			endcase
		end
	end

	// Sums and offsets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				off_q[i] <= '0;
				sum_q[i] <= '0;
			end
		end else if (issue) begin
			case (q_item.cls)
				CLS_LOAD: begin
					for (int i = 0; i < AXES; i++) begin
						off_q[i] <= s[i];
					end
				end
				CLS_START: begin
					for (int i = 0; i < AXES; i++) begin
						off_q[i] <= '0;
						sum_q[i] <= '0;
					end
				end
				default: begin
					if (run_q) begin
						for (int i = 0; i < AXES; i++) begin
							sum_q[i] <= sum_q[i] + sum_t'(s[i]);
						end
					end
				end
			endcase
		end else if (st_q == ST_DIV && div_rsp.done) begin
			off_q[axis_q] <= off_new;
		end
	end

	// Control: run state, sequencer, result valid, config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			axis_q      <= AXIS_X;
			go_q        <= 1'b0;
			taken_q     <= '0;
			run_q       <= 1'b0;
			res_valid_q <= 1'b0;
			count_cfg_q <= COUNT_W'(1);
			grav_q      <= '0;
		end else begin
			go_q <= div_kick;
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_SAMPLE_COUNT:  count_cfg_q <= cfg.data;
					REG_GRAVITY_VALUE: grav_q <= cfg.data[GRAV_W-1:0];
					default: ;
				endcase
			end
			if (issue) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (issue) begin
						case (q_item.cls)
							CLS_LOAD: begin
								run_q   <= 1'b0;
								taken_q <= '0;
							end
							CLS_START: begin
								run_q   <= 1'b1;
								taken_q <= '0;
							end
							default: begin
								if (run_q) begin
									taken_q <= taken_nx[COUNT_W-1:0];
									if (run_end) begin
										run_q  <= 1'b0;
										st_q   <= ST_DIV;
										axis_q <= AXIS_X;
									end
								end
							end
						endcase
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						if (axis_q == AXIS_Z) begin
							st_q <= ST_IDLE;
						end else begin
							axis_q <= axis_q + 1'b1;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[hdl/imu_offset_calibration_core.sv]
// IMU offset calibration core: subtracts stored per-axis offsets from each
// sample, and averages a run of sample_count samples into new offsets after a
// start command (z also loses gravity_value), or takes offsets from a load
// command. Each request yields one result. The back end takes a sample, start
// or load request without a busy state, so the block sustains one request per
// cycle while results are taken and no averages are being worked; a request
// is written into the queue, then into the result register. The sample that
// closes a calibration run returns its result at once, then the shared
// one-bit-per-cycle divider works the three axis averages in turn; the
// two-entry queue keeps accepting requests meanwhile until full, and the next
// one is served when the new offsets are in place. Configuration writes are
// taken at any time and are meant for an idle block.
// Depends on imuoc_pkg, imuoc_if, imuoc_front, imuoc_div, imuoc_back.
module imu_offset_calibration_core import imuoc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	imuoc_samp_if.sink    samp,
	imuoc_res_if.source   res,
	imuoc_cfg_if.sink     cfg
);

	item_t    q_item;
	logic     q_valid;
	logic     q_pop;
	div_req_t div_req;
	div_rsp_t div_rsp;

	// Accept and classify requests
	imuoc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.samp    (samp),
		.q_item  (q_item),
		.q_valid (q_valid),
		.q_pop   (q_pop)
	);

	// Execute requests and produce results
	imuoc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_item  (q_item),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.cfg     (cfg),
		.res     (res),
		.div_req (div_req),
		.div_rsp (div_rsp)
	);

	// Average the run sums
	imuoc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for imu_offset_calibration_core: predicts every result
// from its own copy of the offsets, sums and run state. Depends on imuoc_pkg and imuoc_if.
module tb;
	import imuoc_pkg::*;

	localparam int CLK_PERIOD    = 4;
	localparam int RESET_CYCLES  = 5;
	// Covers the divider's three axis averages after a closing sample, plus the pipeline
	localparam int SETTLE_CYCLES = 200;
	localparam int LONG_HOLD     = 250;
	localparam int TIMEOUT_NS    = 10_000_000;
	localparam int FULL_RUN      = 100;

	// Spare command code, handled as a sample
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		corr_t x;
		corr_t y;
		corr_t z;
		logic  calibrating;
		logic  updated;
	} correction_t;

	logic clk = 1'b0;
	logic arst_n;

	imuoc_samp_if samp_bus();
	imuoc_res_if  res_bus();
	imuoc_cfg_if  cfg_bus();

	imu_offset_calibration_core dut (
		.clk   (clk),
		.arst_n(arst_n),
		.samp  (samp_bus),
		.res   (res_bus),
		.cfg   (cfg_bus)
	);

	// Predicted block state and registers
	samp_t       axis_offset_now [AXES];
	int          axis_total [AXES];
	logic [15:0] run_samples;
	logic        run_open;
	logic [15:0] cfg_sample_count;
	logic [GRAV_W-1:0] cfg_gravity;

	correction_t corrections_due [$];

	int  errors       = 0;
	int  items_sent   = 0;
	int  runs_closed  = 0;
	int  loads_sent   = 0;
	int  reg_writes   = 0;
	int  hold_left    = 0;
	int  stall_left   = 0;
	bit  idling_on    = 1'b1;

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic samp_t clamp_offset(input int v);
		if (v > 32767) begin
			return 16'sh7FFF;
		end else if (v < -32768) begin
			return 16'sh8000;
		end
		return samp_t'(v);
	endfunction

	// Advance the predicted state by one request and queue its result
	function automatic void predict_request(input logic [1:0] cmd, input samp_t sx,
		input samp_t sy, input samp_t sz);
		samp_t       s [AXES];
		int          corr [AXES];
		int          target;
		logic        updated;
		correction_t due;
		s[0] = sx;
		s[1] = sy;
		s[2] = sz;
		updated = 1'b0;
		if (cmd == CMD_LOAD) begin
			for (int i = 0; i < AXES; i++) begin
				axis_offset_now[i] = s[i];
				corr[i] = 0;
			end
			run_open = 1'b0;
			run_samples = '0;
			loads_sent++;
		end else if (cmd == CMD_START) begin
			for (int i = 0; i < AXES; i++) begin
				axis_offset_now[i] = '0;
				axis_total[i] = 0;
				corr[i] = int'(s[i]);
			end
			run_samples = '0;
			run_open = 1'b1;
		end else begin
			for (int i = 0; i < AXES; i++) begin
				corr[i] = int'(s[i]) - int'(axis_offset_now[i]);
			end
			if (run_open) begin
				target = (cfg_sample_count == 0) ? 1 : int'(cfg_sample_count);
				for (int i = 0; i < AXES; i++) begin
					axis_total[i] += int'(s[i]);
				end
				run_samples = run_samples + 16'd1;
				// Close the run: averages truncate toward zero, z also loses gravity
				if (int'(run_samples) >= target) begin
					for (int i = 0; i < AXES; i++) begin
						axis_offset_now[i] = clamp_offset(axis_total[i] / target);
					end
					axis_offset_now[2] = clamp_offset(axis_total[2] / target -
						int'(cfg_gravity));
					run_open = 1'b0;
					updated = 1'b1;
					runs_closed++;
				end
			end
		end
		due.x = corr_t'(corr[0]);
		due.y = corr_t'(corr[1]);
		due.z = corr_t'(corr[2]);
		due.calibrating = run_open;
		due.updated = updated;
		corrections_due.push_back(due);
	endfunction

	function automatic void compare_field(input string name, input corr_t want,
		input corr_t got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// Check one accepted result against the oldest prediction
	task automatic check_result();
		correction_t want;
		if (corrections_due.size() == 0) begin
			$error("result with no request pending: corrected_x %0d", res_bus.corrected_x);
			errors++;
			return;
		end
		want = corrections_due.pop_front();
		compare_field("corrected_x", want.x, res_bus.corrected_x);
		compare_field("corrected_y", want.y, res_bus.corrected_y);
		compare_field("corrected_z", want.z, res_bus.corrected_z);
		compare_field("calibrating", corr_t'(want.calibrating), corr_t'(res_bus.calibrating));
		compare_field("offsets_updated", corr_t'(want.updated),
			corr_t'(res_bus.offsets_updated));
	endtask

	always @(posedge clk) begin
		if (arst_n && res_bus.valid === 1'b1 && res_bus.ready) begin
			check_result();
		end
	end

	// Result ready: long hold-offs first, then random stall bursts
	always @(negedge clk) begin
		if (hold_left > 0) begin
			res_bus.ready = 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			res_bus.ready = 1'b0;
			stall_left--;
		end else if (idling_on && $urandom_range(0, 7) == 0) begin
			res_bus.ready = 1'b0;
			stall_left = $urandom_range(1, 12) - 1;
		end else begin
			res_bus.ready = 1'b1;
		end
	end

	function automatic samp_t random_axis();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return '0;
			default: return samp_t'($urandom);
		endcase
	endfunction

	function automatic logic [GRAV_W-1:0] pick_gravity();
		case ($urandom_range(0, 6))
			0: return '0;
			1: return 15'd2048;
			2: return 15'd4096;
			3: return 15'd8192;
			4: return 15'd16384;
			default: return GRAV_W'($urandom_range(0, 16384));
		endcase
	endfunction

	// Offer one request, with an optional idle burst ahead of it
	task automatic send_request(input logic [1:0] cmd, input samp_t sx, input samp_t sy,
		input samp_t sz);
		int gap;
		@(negedge clk);
		if (idling_on && $urandom_range(0, 5) == 0) begin
			samp_bus.valid = 1'b0;
			gap = $urandom_range(1, 12);
			repeat (gap) @(negedge clk);
		end
		samp_bus.valid = 1'b1;
		samp_bus.command = cmd;
		samp_bus.sample_x = sx;
		samp_bus.sample_y = sy;
		samp_bus.sample_z = sz;
		do @(posedge clk); while (!samp_bus.ready);
		predict_request(cmd, sx, sy, sz);
		items_sent++;
	endtask

	// Drop the request, wait for every pending result, then let the block go quiet
	task automatic drain_results(input int extra);
		@(negedge clk);
		samp_bus.valid = 1'b0;
		while (corrections_due.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_bus.valid = 1'b1;
		cfg_bus.index = index;
		cfg_bus.data = data;
		do @(posedge clk); while (!cfg_bus.ready);
		case (index)
			REG_SAMPLE_COUNT: cfg_sample_count = data;
			REG_GRAVITY_VALUE: cfg_gravity = data[GRAV_W-1:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	// Zero offsets after reset: results carry the raw samples
	task automatic test_plain_samples();
		send_request(CMD_SAMPLE, 16'sh7FFF, 16'sh8000, 16'sh0000);
		send_request(CMD_SAMPLE, -16'sd1, 16'sd1, 16'sh8000);
		send_request(CMD_UNUSED, 16'sd12345, -16'sd12345, 16'sh7FFF);
	endtask

	// Loaded extreme offsets drive the corrected fields to their full range
	task automatic test_load_offsets();
		send_request(CMD_LOAD, 16'sh8000, 16'sh7FFF, 16'sd1);
		send_request(CMD_SAMPLE, 16'sh7FFF, 16'sh8000, 16'sh8000);
		send_request(CMD_SAMPLE, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
		send_request(CMD_UNUSED, '0, '0, '0);
	endtask

	task automatic test_calibration_runs();
		// Zero sample_count acts as one: the first sample closes the run
		drain_results(SETTLE_CYCLES);
		write_reg(REG_SAMPLE_COUNT, 16'd0);
		write_reg(REG_GRAVITY_VALUE, 16'd0);
		send_request(CMD_START, 16'sd5, 16'sd5, 16'sd5);
		send_request(CMD_SAMPLE, -16'sd7, 16'sd9, 16'sd100);
		send_request(CMD_SAMPLE, '0, '0, '0);

		// Truncation toward zero, and z saturating once gravity is taken off
		drain_results(SETTLE_CYCLES);
		write_reg(REG_SAMPLE_COUNT, 16'd2);
		write_reg(REG_GRAVITY_VALUE, 16'd16384);
		send_request(CMD_START, 16'sd1, 16'sd2, 16'sd3);
		send_request(CMD_SAMPLE, 16'sh8000, 16'sh7FFF, 16'sh8000);
		send_request(CMD_SAMPLE, -16'sd32767, 16'sh7FFF, -16'sd32767);
		send_request(CMD_SAMPLE, 16'sd1, 16'sd2, 16'sd3);

		// A second start throws away the partial run
		send_request(CMD_START, '0, '0, '0);
		send_request(CMD_SAMPLE, 16'sd100, 16'sd200, 16'sd300);
		send_request(CMD_START, -16'sd9, 16'sd9, '0);
		send_request(CMD_SAMPLE, 16'sd2, 16'sd4, 16'sd6);
		send_request(CMD_SAMPLE, 16'sd4, 16'sd8, 16'sd12);

		// A load aborts the run in progress
		send_request(CMD_START, '0, '0, '0);
		send_request(CMD_SAMPLE, 16'sd50, 16'sd60, 16'sd70);
		send_request(CMD_LOAD, 16'sd10, 16'sd20, 16'sd30);
		send_request(CMD_SAMPLE, 16'sd10, 16'sd20, 16'sd30);
	endtask

	// Hold results off long enough to fill the block, then pause until it drains
	task automatic test_backpressure();
		int j;
		drain_results(SETTLE_CYCLES);
		write_reg(REG_SAMPLE_COUNT, 16'd4);
		write_reg(REG_GRAVITY_VALUE, 16'd8192);
		@(posedge clk);
		hold_left = LONG_HOLD;
		send_request(CMD_START, random_axis(), random_axis(), random_axis());
		for (j = 0; j < 10; j++) begin
			send_request(CMD_SAMPLE, random_axis(), random_axis(), random_axis());
		end
		send_request(CMD_LOAD, random_axis(), random_axis(), random_axis());
		send_request(CMD_START, random_axis(), random_axis(), random_axis());
		for (j = 0; j < 4; j++) begin
			send_request(CMD_SAMPLE, random_axis(), random_axis(), random_axis());
		end
		drain_results(0);
		for (j = 0; j < 5; j++) begin
			send_request(CMD_SAMPLE, random_axis(), random_axis(), random_axis());
		end
	endtask

	// Mostly complete runs with random content, some broken runs and noise
	task automatic test_random_traffic(input int n_items, input bit with_idling);
		int          stop_at;
		int          run_len;
		int          j;
		logic [15:0] new_count;
		idling_on = with_idling;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			drain_results(SETTLE_CYCLES);
			case ($urandom_range(0, 9))
				0: new_count = '0;
				1: new_count = 16'd1;
				2: new_count = 16'($urandom_range(7, 40));
				default: new_count = 16'($urandom_range(2, 6));
			endcase
			write_reg(REG_SAMPLE_COUNT, new_count);
			write_reg(REG_GRAVITY_VALUE, CFG_DATA_W'(pick_gravity()));
			repeat ($urandom_range(10, 25)) begin
				if ($urandom_range(0, 9) < 7) begin
					send_request(CMD_START, random_axis(), random_axis(), random_axis());
					run_len = (cfg_sample_count == 0) ? 1 : int'(cfg_sample_count);
					for (j = 0; j < run_len; j++) begin
						if ($urandom_range(0, 39) == 0) begin
							send_request($urandom_range(0, 1) ? CMD_START : CMD_LOAD,
								random_axis(), random_axis(), random_axis());
							break;
						end
						send_request(($urandom_range(0, 9) == 0) ? CMD_UNUSED : CMD_SAMPLE,
							random_axis(), random_axis(), random_axis());
					end
					repeat ($urandom_range(1, 3)) begin
						send_request(CMD_SAMPLE, random_axis(), random_axis(), random_axis());
					end
				end else begin
					send_request(2'($urandom_range(0, 3)), random_axis(), random_axis(),
						random_axis());
				end
			end
		end
	endtask

	// Long run at full rate, z pinned low to saturate
	task automatic test_full_length_run();
		int j;
		idling_on = 1'b0;
		drain_results(SETTLE_CYCLES);
		write_reg(REG_SAMPLE_COUNT, 16'(FULL_RUN));
		write_reg(REG_GRAVITY_VALUE, 16'd8192);
		send_request(CMD_START, '0, '0, '0);
		for (j = 0; j < FULL_RUN; j++) begin
			send_request(CMD_SAMPLE, random_axis(), 16'sh7FFF, 16'sh8000);
		end
		repeat (3) begin
			send_request(CMD_SAMPLE, random_axis(), random_axis(), random_axis());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		samp_bus.valid = 1'b0;
		samp_bus.command = CMD_SAMPLE;
		samp_bus.sample_x = '0;
		samp_bus.sample_y = '0;
		samp_bus.sample_z = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_SAMPLE_COUNT;
		cfg_bus.data = '0;
		res_bus.ready = 1'b0;
		for (int i = 0; i < AXES; i++) begin
			axis_offset_now[i] = '0;
			axis_total[i] = 0;
		end
		run_samples = '0;
		run_open = 1'b0;
		cfg_sample_count = 16'd1;
		cfg_gravity = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_plain_samples();
		test_load_offsets();
		test_calibration_runs();
		test_backpressure();
		test_random_traffic(700, 1'b1);
		test_random_traffic(150, 1'b0);
		test_full_length_run();
		drain_results(SETTLE_CYCLES);

		$display("Covered %0d requests: %0d calibration runs closed, %0d offset loads,",
			items_sent, runs_closed, loads_sent);
		$display("%0d register writes, sample_count from 0 to %0d, stalls on both sides.",
			reg_writes, FULL_RUN);
		if (errors == 0) begin
			$display("imu_offset_calibration_core test passed");
		end else begin
			$display("imu_offset_calibration_core test failed");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#(TIMEOUT_NS);
		$display("imu_offset_calibration_core test failed");
		$finish;
	end

endmodule

[imu_offset_calibration_core.f]
hdl/imuoc_pkg.sv
hdl/imuoc_if.sv
hdl/imuoc_front.sv
hdl/imuoc_div.sv
hdl/imuoc_back.sv
hdl/imu_offset_calibration_core.sv
tb/tb.sv
